FILE: rtl/art_pkg.sv
// Package for the acknowledgement retransmit tracker.
// Holds the table entry type, command and result codes, state codes and register indexes.
// No dependencies.
package art_pkg;

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_ACK      = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ACCEPTED   = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_ACKED      = 3'd2,
        KIND_UNMATCHED  = 3'd3,
        KIND_RETRANSMIT = 3'd4,
        KIND_GAVE_UP    = 3'd5,
        KIND_TICK_DONE  = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_RD,
        S_EVAL,
        S_FIN
    } t_state;

    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_TICK_STEP   = 2'd2;

    localparam logic [15:0] RST_ACK_TIMEOUT = 16'd1000;
    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd5;
    localparam logic [9:0]  RST_TICK_STEP   = 10'd10;

    typedef struct packed {
        logic [7:0]         peer;
        logic [7:0]         own;
        logic [7:0]         seq;
        logic [7:0]         tag;
        logic signed [16:0] timer;
        logic [3:0]         retries;
    } t_entry;

endpackage

FILE: rtl/ack_retransmit_tracker_unit.sv
// Top level of the acknowledgement retransmit tracker: control sequencer and result register.
// Depends on art_pkg and art_ram.
//
//   channel   direction  handshake                  word
//   input     in         i_in_valid / o_in_stall    command, peer, own, seq, tag
//   result    out        o_out_valid / i_out_stall  kind, entry fields, retries, last
//   config    in         i_cfg_valid / o_cfg_ready  register index and data
//
// A register word is handled in S_REG before the next word is accepted. An ack or a tick
// walks the table through the entry memory, reading each stored entry in S_RD and then
// deciding in S_EVAL whether to write it back, and ends in S_FIN; default depth is 16.
// Removal compacts the table during the walk, so order is kept oldest first.
// Synchronous reset: clears control state and count, sets config defaults; entries need none.
// A stalled result holds the walk; no new word is taken until the last result is loaded.
module ack_retransmit_tracker_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_peer_id,
    input  logic [7:0]  i_own_id,
    input  logic [7:0]  i_seq_number,
    input  logic [7:0]  i_payload_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_entry_peer,
    output logic [7:0]  o_entry_own,
    output logic [7:0]  o_entry_seq,
    output logic [7:0]  o_entry_tag,
    output logic [3:0]  o_retries_left,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    art_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, r_rd, r_wr;
    art_pkg::t_cmd   r_cmd;
    logic [7:0]      r_peer, r_own, r_seq, r_tag;
    logic            r_found;
    art_pkg::t_entry r_hold;
    logic [15:0]     r_timeout;
    logic [3:0]      r_retry;
    logic [9:0]      r_step;

    logic            r_ovalid, r_olast;
    logic [2:0]      r_okind;
    logic [7:0]      r_opeer, r_oown, r_oseq, r_otag;
    logic [3:0]      r_oret;

    logic            w_accept, w_free, w_full;
    logic            w_re, w_we, w_emit, w_elast, w_adv, w_match, w_expired;
    logic [AW-1:0]   w_raddr, w_waddr;
    art_pkg::t_entry w_wdata, w_rdata;
    art_pkg::t_kind  w_ekind;
    logic [7:0]      w_epeer, w_eown, w_eseq, w_etag;
    logic [3:0]      w_eret, w_rdec;
    logic signed [16:0] w_tsub;
    logic [CW-1:0]   w_rd_next;

    assign w_accept    = i_in_valid && (r_state == art_pkg::S_IDLE);
    assign o_in_stall  = (r_state != art_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_free      = !r_ovalid || !i_out_stall;
    assign w_full      = (r_count >= CW'(TABLE_DEPTH));
    assign w_rd_next   = r_rd + CW'(1);
    assign w_tsub      = w_rdata.timer - $signed({7'd0, r_step});
    assign w_expired   = w_tsub[16] || (w_tsub == 17'sd0);
    assign w_rdec      = (w_rdata.retries == 4'd0) ? 4'd0 : w_rdata.retries - 4'd1;
    assign w_match     = (r_cmd == art_pkg::CMD_ACK) && !r_found &&
                         (w_rdata.seq == r_seq) && (w_rdata.peer == r_peer) &&
                         (w_rdata.own == r_own);

    art_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Datapath controls for the current state.
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_rd[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_wr[AW-1:0];
        w_wdata = w_rdata;
        w_emit  = 1'b0;
        w_elast = 1'b0;
        w_adv   = 1'b0;
        w_ekind = art_pkg::KIND_TICK_DONE;
        w_epeer = w_rdata.peer;
        w_eown  = w_rdata.own;
        w_eseq  = w_rdata.seq;
        w_etag  = w_rdata.tag;
        w_eret  = 4'd0;
        unique case (r_state)
            art_pkg::S_IDLE: begin
            end
            art_pkg::S_REG: begin
                w_emit  = 1'b1;
                w_elast = 1'b1;
                w_adv   = w_free;
                w_epeer = r_peer;
                w_eown  = r_own;
                w_eseq  = r_seq;
                w_etag  = r_tag;
                w_waddr = r_count[AW-1:0];
                w_wdata = '{peer: r_peer, own: r_own, seq: r_seq, tag: r_tag,
                            timer: $signed({1'b0, r_timeout}), retries: r_retry};
                if (w_full) begin
                    w_ekind = art_pkg::KIND_FULL;
                end else begin
                    w_ekind = art_pkg::KIND_ACCEPTED;
                    w_eret  = r_retry;
                    w_we    = w_free;
                end
            end
            art_pkg::S_RD: begin
                w_re = 1'b1;
            end
            art_pkg::S_EVAL: begin
                if (r_cmd == art_pkg::CMD_ACK) begin
                    w_adv = 1'b1;
                    w_we  = !w_match;
                end else if (w_expired) begin
                    w_emit = 1'b1;
                    w_adv  = w_free;
                    if (w_rdec == 4'd0) begin
                        w_ekind = art_pkg::KIND_GAVE_UP;
                    end else begin
                        w_ekind = art_pkg::KIND_RETRANSMIT;
                        w_eret  = w_rdec;
                        w_we    = w_free;
                        w_wdata.timer   = $signed({1'b0, r_timeout});
                        w_wdata.retries = w_rdec;
                    end
                end else begin
                    w_adv = 1'b1;
                    w_we  = 1'b1;
                    w_wdata.timer = w_tsub;
                end
            end
            art_pkg::S_FIN: begin
                w_emit  = 1'b1;
                w_elast = 1'b1;
                w_adv   = w_free;
                if (r_cmd == art_pkg::CMD_TICK) begin
                    w_ekind = art_pkg::KIND_TICK_DONE;
                    w_epeer = 8'd0;
                    w_eown  = 8'd0;
                    w_eseq  = 8'd0;
                    w_etag  = 8'd0;
                end else if (r_found) begin
                    w_ekind = art_pkg::KIND_ACKED;
                    w_epeer = r_hold.peer;
                    w_eown  = r_hold.own;
                    w_eseq  = r_hold.seq;
                    w_etag  = r_hold.tag;
                    w_eret  = r_hold.retries;
                end else begin
                    w_ekind = art_pkg::KIND_UNMATCHED;
                    w_epeer = r_peer;
                    w_eown  = r_own;
                    w_eseq  = r_seq;
                    w_etag  = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            art_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (art_pkg::t_cmd'(i_command))
                        art_pkg::CMD_REGISTER: n_state = art_pkg::S_REG;
                        art_pkg::CMD_ACK:
                            n_state = (r_count == '0) ? art_pkg::S_FIN : art_pkg::S_RD;
                        art_pkg::CMD_TICK:
                            n_state = (r_count == '0 || r_step == 10'd0) ?
                                      art_pkg::S_FIN : art_pkg::S_RD;
                        art_pkg::CMD_NONE: n_state = art_pkg::S_IDLE;
                        default: n_state = art_pkg::S_IDLE;
                    endcase
                end
            end
            art_pkg::S_REG: if (w_adv) n_state = art_pkg::S_IDLE;
            art_pkg::S_RD:  n_state = art_pkg::S_EVAL;
            art_pkg::S_EVAL: begin
                if (w_adv) begin
                    n_state = (w_rd_next == r_count) ? art_pkg::S_FIN : art_pkg::S_RD;
                end
            end
            art_pkg::S_FIN: if (w_adv) n_state = art_pkg::S_IDLE;
            default: n_state = art_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= art_pkg::S_IDLE;
            r_count   <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_found   <= 1'b0;
            r_cmd     <= art_pkg::CMD_NONE;
            r_timeout <= art_pkg::RST_ACK_TIMEOUT;
            r_retry   <= art_pkg::RST_RETRY_LIMIT;
            r_step    <= art_pkg::RST_TICK_STEP;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    art_pkg::REG_ACK_TIMEOUT: r_timeout <= i_cfg_data;
                    art_pkg::REG_RETRY_LIMIT: r_retry   <= i_cfg_data[3:0];
                    art_pkg::REG_TICK_STEP:   r_step    <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_cmd   <= art_pkg::t_cmd'(i_command);
                r_rd    <= '0;
                r_found <= 1'b0;
                // A tick with no step leaves the table as it is.
                r_wr    <= (i_command == art_pkg::CMD_TICK && r_step == 10'd0) ?
                           r_count : '0;
            end
            if (r_state == art_pkg::S_EVAL && w_adv) begin
                r_rd <= w_rd_next;
                if (w_we) r_wr <= r_wr + CW'(1);
                if (w_match) r_found <= 1'b1;
            end
            if (r_state == art_pkg::S_REG && w_adv && !w_full) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == art_pkg::S_FIN && w_adv && r_cmd != art_pkg::CMD_REGISTER) begin
                r_count <= r_wr;
            end
            if (w_free) begin
                r_ovalid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_peer <= i_peer_id;
            r_own  <= i_own_id;
            r_seq  <= i_seq_number;
            r_tag  <= i_payload_tag;
        end
        if (r_state == art_pkg::S_EVAL && w_match) begin
            r_hold <= w_rdata;
        end
        if (w_free && w_emit) begin
            r_okind <= w_ekind;
            r_opeer <= w_epeer;
            r_oown  <= w_eown;
            r_oseq  <= w_eseq;
            r_otag  <= w_etag;
            r_oret  <= w_eret;
            r_olast <= w_elast;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_kind  = r_okind;
    assign o_entry_peer   = r_opeer;
    assign o_entry_own    = r_oown;
    assign o_entry_seq    = r_oseq;
    assign o_entry_tag    = r_otag;
    assign o_retries_left = r_oret;
    assign o_last_result  = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("table count above depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == art_pkg::S_RD || r_state == art_pkg::S_EVAL) |-> (r_wr <= r_rd))
        else $error("write pointer passed read pointer");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == art_pkg::S_EVAL) |-> (r_rd < r_count))
        else $error("walk beyond stored entries");

    a_final_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == art_pkg::S_FIN && w_free) |=> (o_out_valid && o_last_result))
        else $error("final result not flagged last");

endmodule

FILE: rtl/art_ram.sv
// Entry store of the tracker: one write port and one read port, read data registered.
// Depends on art_pkg for the entry type.
module art_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  art_pkg::t_entry   i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output art_pkg::t_entry   o_rdata
);

    art_pkg::t_entry r_mem [DEPTH];
    art_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
